@@ design/pse_pkg.sv @@
package pse_pkg;

   localparam int PHASE_COUNT_DEF = 7;
   localparam int SLOTS = 8;

   localparam logic [7:0] SYNC_BYTE   = 8'hFF;
   localparam logic [7:0] MARK_END    = 8'hA0;
   localparam logic [7:0] MARK_BASE   = 8'hA0;
   localparam logic [7:0] MARK_LOWNIB = 8'h0F;

   localparam logic [2:0] KIND_SAMPLE = 3'd0;
   localparam logic [2:0] KIND_SYNC   = 3'd1;
   localparam logic [2:0] KIND_START  = 3'd2;
   localparam logic [2:0] KIND_PHASE  = 3'd3;
   localparam logic [2:0] KIND_IDLE   = 3'd4;

   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [62:0] MAX63 = {63{1'b1}};
   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
   localparam logic [14:0] MAX15 = 15'h7FFF;

   typedef struct packed {
      logic        func;
      logic [15:0] current_raw;
      logic [14:0] bus_voltage_mv;
      logic [31:0] time_us;
      logic [7:0]  marker_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  phase;
      logic [31:0] cycle;
      logic [14:0] current;
      logic [14:0] average;
      logic [14:0] peak;
      logic [31:0] duration_us;
      logic [62:0] energy;
      logic        has_samples;
      logic        last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       load;        // capture request
      logic       mul1;        // first product stage
      logic       mul2;        // second product stage
      logic       sample_upd;  // update slot with sample
      logic       marker_upd;  // apply phase marker
      logic       sync_set;
      logic       end_prep;    // close cycle bookkeeping
      logic       div_start;
      logic       div_step;
      logic       emit_simple; // form one-result record
      logic [2:0] simple_kind;
      logic       emit_summary;
      logic [2:0] sum_slot;
      logic       sum_last;
      logic       clear;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic       func;
      logic [7:0] mark;
      logic       sync_seen;
      logic       cycle_open;
   } sts_type;

endpackage

@@ design/pse_div.sv @@
// Restoring divider, one quotient bit per cycle while step is high (48 / 32).
module pse_div (
   input  logic        clock,
   input  logic        start,
   input  logic        step,
   input  logic [47:0] dividend,
   input  logic [31:0] divisor,
   output logic [47:0] quotient
);
   logic [47:0] q_ff, q_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] d_ff;
   logic [32:0] trial;

   always_comb begin
      q_in  = q_ff;
      r_in  = r_ff;
      trial = {r_ff, q_ff[47]};
      if (start) begin
         q_in = dividend;
         r_in = '0;
      end else if (step) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = 32'(trial - {1'b0, d_ff});
            q_in = {q_ff[46:0], 1'b1};
         end else begin
            r_in = trial[31:0];
            q_in = {q_ff[46:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) d_ff <= divisor;
   end

   assign quotient = q_ff;
endmodule

@@ design/pse_datapath.sv @@
module pse_datapath #(
   parameter int PHASE_COUNT = pse_pkg::PHASE_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  pse_pkg::req_type req_data,
   input  pse_pkg::ctl_type ctl,
   output pse_pkg::sts_type sts,
   output pse_pkg::rsp_type rec
);
   logic [47:0] csum_ff [pse_pkg::SLOTS];
   logic [62:0] esum_ff [pse_pkg::SLOTS];
   logic [14:0] peak_ff [pse_pkg::SLOTS];
   logic [31:0] cnt_ff  [pse_pkg::SLOTS];
   logic [31:0] st_ff   [pse_pkg::SLOTS];
   logic [31:0] et_ff   [pse_pkg::SLOTS];
   logic [2:0]  open_ff;
   logic        copen_ff, sync_ff;
   logic [31:0] cyc_ff, lst_ff;
   pse_pkg::req_type r_ff;
   logic [14:0] cur_ff;
   logic [29:0] p1_ff;
   logic [62:0] de_ff;
   logic [62:0] total_ff;
   logic [2:0]  slot_ff;
   pse_pkg::rsp_type rec_ff, rec_in;

   logic [14:0] cur_c;
   logic [31:0] dt_c;
   logic [2:0]  np_c;
   logic [47:0] cs_add;
   logic [63:0] es_add, tot_add;
   logic [47:0] quot;
   logic [14:0] avg_c;

   assign cur_c  = req_data.current_raw[15] ? 15'd0 : req_data.current_raw[14:0];
   assign dt_c   = r_ff.time_us - lst_ff;
   assign np_c   = r_ff.marker_byte[2:0];
   assign cs_add = csum_ff[slot_ff] + {33'd0, cur_ff};
   assign es_add = {1'b0, esum_ff[slot_ff]} + {1'b0, de_ff};
   assign tot_add = {1'b0, total_ff} + {1'b0, esum_ff[ctl.sum_slot]};
   assign avg_c  = (quot[47:15] != '0) ? pse_pkg::MAX15 : quot[14:0];

   pse_div u_div (
      .clock    (clock),
      .start    (ctl.div_start),
      .step     (ctl.div_step),
      .dividend (csum_ff[ctl.sum_slot]),
      .divisor  (cnt_ff[ctl.sum_slot]),
      .quotient (quot)
   );

   // capture the item and form the energy product in two stages
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         r_ff   <= req_data;
         cur_ff <= cur_c;
      end
      if (ctl.mul1) begin
         p1_ff   <= 30'(cur_ff * r_ff.bus_voltage_mv);
         slot_ff <= copen_ff ? open_ff : 3'd0;
      end
      if (ctl.mul2) de_ff <= 63'(p1_ff * dt_c);
      rec_ff <= rec_in;
   end

   // record builder
   always_comb begin
      rec_in = rec_ff;
      if (ctl.emit_simple) begin
         rec_in = '0;
         rec_in.kind = ctl.simple_kind;
         rec_in.last = 1'b1;
         rec_in.cycle = cyc_ff;
         if (ctl.simple_kind == pse_pkg::KIND_SAMPLE) begin
            rec_in.phase   = slot_ff;
            rec_in.current = cur_ff;
         end else if (ctl.simple_kind == pse_pkg::KIND_START) begin
            rec_in.phase = 3'd1;
            rec_in.cycle = cyc_ff + 32'd1;
         end
      end else if (ctl.emit_summary) begin
         rec_in = '0;
         rec_in.cycle = cyc_ff;
         rec_in.last  = ctl.sum_last;
         if (ctl.sum_last) begin
            rec_in.kind = pse_pkg::KIND_IDLE;
            rec_in.energy = total_ff;
            if (cnt_ff[0] != '0) begin
               rec_in.average = avg_c;
               rec_in.has_samples = 1'b1;
            end
            rec_in.peak = peak_ff[0];
         end else begin
            rec_in.kind  = pse_pkg::KIND_PHASE;
            rec_in.phase = ctl.sum_slot;
            if (cnt_ff[ctl.sum_slot] != '0) begin
               rec_in.average = avg_c;
               rec_in.peak = peak_ff[ctl.sum_slot];
               rec_in.duration_us = et_ff[ctl.sum_slot] - st_ff[ctl.sum_slot];
               rec_in.energy = esum_ff[ctl.sum_slot];
               rec_in.has_samples = 1'b1;
            end
         end
      end
   end

   // statistics state
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int i = 0; i < pse_pkg::SLOTS; i++) begin
            csum_ff[i] <= '0; esum_ff[i] <= '0; peak_ff[i] <= '0;
            cnt_ff[i] <= '0; st_ff[i] <= '0; et_ff[i] <= '0;
         end
         open_ff  <= '0;
         copen_ff <= 1'b0;
      end else begin
         if (ctl.sample_upd) begin
            csum_ff[slot_ff] <= (cs_add < csum_ff[slot_ff]) ? pse_pkg::MAX48 : cs_add;
            esum_ff[slot_ff] <= es_add[63] ? pse_pkg::MAX63 : es_add[62:0];
            if (cnt_ff[slot_ff] != pse_pkg::MAX32)
               cnt_ff[slot_ff] <= cnt_ff[slot_ff] + 32'd1;
            if (cur_ff > peak_ff[slot_ff]) peak_ff[slot_ff] <= cur_ff;
         end
         if (ctl.marker_upd) begin
            if (copen_ff && open_ff >= 3'd1 && open_ff < np_c)
               et_ff[open_ff] <= r_ff.time_us;
            open_ff <= np_c;
            st_ff[np_c] <= r_ff.time_us;
            if (np_c == 3'd1) copen_ff <= 1'b1;
         end
         if (ctl.end_prep && copen_ff && open_ff >= 3'd1
             && 32'(open_ff) <= 32'(PHASE_COUNT))
            et_ff[open_ff] <= r_ff.time_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= 1'b0;
         cyc_ff  <= '0;
         lst_ff  <= '0;
      end else begin
         if (ctl.sync_set) sync_ff <= 1'b1;
         if (ctl.end_prep) cyc_ff <= cyc_ff + 32'd1;
         if (ctl.mul2) lst_ff <= r_ff.time_us;
      end
   end

   // running total of phase energies
   always_ff @(posedge clock) begin
      if (ctl.end_prep) total_ff <= '0;
      else if (ctl.emit_summary && !ctl.sum_last && cnt_ff[ctl.sum_slot] != '0)
         total_ff <= tot_add[63] ? pse_pkg::MAX63 : tot_add[62:0];
   end

   assign sts.func       = r_ff.func;
   assign sts.mark       = r_ff.marker_byte;
   assign sts.sync_seen  = sync_ff;
   assign sts.cycle_open = copen_ff;
   assign rec = rec_ff;
endmodule

@@ design/pse_ctrl.sv @@
module pse_ctrl #(
   parameter int PHASE_COUNT = pse_pkg::PHASE_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  pse_pkg::sts_type sts,
   output pse_pkg::ctl_type ctl
);
   localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_MUL1 = 4'd2, S_MUL2 = 4'd3,
      S_UPD = 4'd4, S_EMIT = 4'd5, S_OUT = 4'd6, S_DSTART = 4'd7, S_DIV = 4'd8,
      S_SUM = 4'd9, S_SOUT = 4'd10, S_CLR = 4'd11;

   logic [3:0] st_ff, st_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [2:0] slot_ff, slot_in;
   logic       last_ff, last_in;
   logic [2:0] kind_ff, kind_in;
   logic       mk_phase;

   assign mk_phase = (sts.mark > pse_pkg::MARK_BASE)
      && ({24'd0, sts.mark} <= 32'(pse_pkg::MARK_BASE) + 32'(PHASE_COUNT));
   assign req_ready = (st_ff == S_IDLE);
   assign rsp_valid = (st_ff == S_OUT) || (st_ff == S_SOUT);

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; slot_in = slot_ff;
      last_in = last_ff; kind_in = kind_ff;
      ctl = '0;
      ctl.simple_kind = kind_ff;
      ctl.sum_slot = slot_ff;
      ctl.sum_last = last_ff;
      case (st_ff)
         S_IDLE: if (req_valid) begin ctl.load = 1'b1; st_in = S_DEC; end
         S_DEC: begin
            st_in = S_IDLE;
            if (!sts.func) st_in = S_MUL1;
            else if (sts.mark == pse_pkg::SYNC_BYTE) begin
               if (!sts.sync_seen) begin
                  ctl.sync_set = 1'b1; kind_in = pse_pkg::KIND_SYNC; st_in = S_EMIT;
               end
            end else if (sts.mark == pse_pkg::MARK_END) begin
               ctl.end_prep = 1'b1;
               slot_in = (PHASE_COUNT >= 1) ? 3'd1 : 3'd0;
               last_in = 1'b0;
               st_in = S_DSTART;
            end else if (mk_phase) begin
               ctl.marker_upd = 1'b1;
               if ((sts.mark & pse_pkg::MARK_LOWNIB) == 8'd1) begin
                  kind_in = pse_pkg::KIND_START; st_in = S_EMIT;
               end
            end
         end
         S_MUL1: begin ctl.mul1 = 1'b1; st_in = S_MUL2; end
         S_MUL2: begin ctl.mul2 = 1'b1; st_in = S_UPD; end
         S_UPD: begin ctl.sample_upd = 1'b1; kind_in = pse_pkg::KIND_SAMPLE; st_in = S_EMIT; end
         S_EMIT: begin ctl.emit_simple = 1'b1; st_in = S_OUT; end
         S_OUT: if (rsp_ready) st_in = S_IDLE;
         S_DSTART: begin ctl.div_start = 1'b1; cnt_in = 6'd48; st_in = S_DIV; end
         S_DIV: begin
            ctl.div_step = 1'b1;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) st_in = S_SUM;
         end
         S_SUM: begin ctl.emit_summary = 1'b1; st_in = S_SOUT; end
         S_SOUT: if (rsp_ready) begin
            if (last_ff) st_in = S_CLR;
            else begin
               if (32'(slot_ff) >= 32'(PHASE_COUNT)) begin
                  slot_in = 3'd0; last_in = 1'b1;
               end else slot_in = slot_ff + 3'd1;
               st_in = S_DSTART;
            end
         end
         S_CLR: begin ctl.clear = 1'b1; st_in = S_IDLE; end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; cnt_ff <= '0; slot_ff <= '0; last_ff <= 1'b0; kind_ff <= '0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; slot_ff <= slot_in;
         last_ff <= last_in; kind_ff <= kind_in;
      end
   end
endmodule

@@ design/phase_segmented_energy_profiler.sv @@
// Channel | Direction | Ports
// req     | in        | req_valid, req_ready, req_data (pse_pkg::req_type)
// rsp     | out       | rsp_valid, rsp_ready, rsp_data (pse_pkg::rsp_type)
// One item at a time. A sample is decoded, then passes two product stages
// and the slot update before its record waits for the output transfer.
// Cycle end: per phase, then idle, a 48-step divide and one record.
// Reset is synchronous and clears all statistics; any number of rsp stall
// cycles holds the current record.
module phase_segmented_energy_profiler #(
   parameter int PHASE_COUNT = pse_pkg::PHASE_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pse_pkg::rsp_type rsp_data
);
   pse_pkg::ctl_type ctl;
   pse_pkg::sts_type sts;

   pse_ctrl #(.PHASE_COUNT(PHASE_COUNT)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .ctl
   );

   pse_datapath #(.PHASE_COUNT(PHASE_COUNT)) u_dp (
      .clock, .reset, .req_data, .ctl, .sts, .rec(rsp_data)
   );

`ifndef SYNTHESIS
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != pse_pkg::KIND_PHASE |-> rsp_data.last)
      else $error("non-summary result without last");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == pse_pkg::KIND_IDLE |-> rsp_data.phase == 3'd0)
      else $error("idle record with phase");
`endif
endmodule

@@ bench/tb_phase_segmented_energy_profiler.sv @@
`timescale 1ns / 100ps

module tb_phase_segmented_energy_profiler;

   localparam int NPH = pse_pkg::PHASE_COUNT_DEF;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   pse_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   pse_pkg::rsp_type rsp_data;

   phase_segmented_energy_profiler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [47:0] cur_sum [pse_pkg::SLOTS];
   logic [62:0] nrg_sum [pse_pkg::SLOTS];
   logic [14:0] pk_cur [pse_pkg::SLOTS];
   logic [31:0] n_samp [pse_pkg::SLOTS];
   logic [31:0] t_start [pse_pkg::SLOTS];
   logic [31:0] t_end [pse_pkg::SLOTS];
   logic [2:0]  open_ph;
   logic        in_cycle;
   logic        synced;
   logic [31:0] cycles_done;
   logic [31:0] prev_stamp;

   pse_pkg::req_type pending_reqs[$];
   pse_pkg::rsp_type expected_recs[$];
   int      n_failures = 0;
   int      n_sent = 0;
   int      n_recs = 0;
   int      n_cycle_ends = 0;
   logic    drain_pause = 1'b0;
   int      long_stall = 0;

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b,
                                           logic [63:0] lim);
      if (a > lim) a = lim;
      if (b > lim - a) return lim;
      return a + b;
   endfunction

   function automatic logic [14:0] slot_avg(int s);
      logic [47:0] q;
      if (n_samp[s] == 0) return '0;
      q = cur_sum[s] / n_samp[s];
      return (q > pse_pkg::MAX15) ? pse_pkg::MAX15 : q[14:0];
   endfunction

   function automatic pse_pkg::rsp_type mk_rec(logic [2:0] kind, logic [2:0] ph,
                                               logic [31:0] cyc, logic last);
      pse_pkg::rsp_type r;
      r = '0;
      r.kind = kind;
      r.phase = ph;
      r.cycle = cyc;
      r.last = last;
      return r;
   endfunction

   task automatic clear_profile();
      for (int s = 0; s < pse_pkg::SLOTS; s++) begin
         cur_sum[s] = '0; nrg_sum[s] = '0; pk_cur[s] = '0;
         n_samp[s] = '0; t_start[s] = '0; t_end[s] = '0;
      end
   endtask

   // compute the records one accepted item produces
   task automatic profile_item(pse_pkg::req_type it);
      logic [14:0] cur;
      logic [31:0] dt;
      logic [63:0] de;
      logic [62:0] total;
      logic [2:0]  s;
      logic [3:0]  np;
      pse_pkg::rsp_type r;
      if (it.func == 1'b0) begin
         cur = it.current_raw[15] ? 15'd0 : it.current_raw[14:0];
         dt = it.time_us - prev_stamp;
         de = 64'(cur) * 64'(it.bus_voltage_mv) * 64'(dt);
         s = in_cycle ? open_ph : 3'd0;
         prev_stamp = it.time_us;
         cur_sum[s] = 48'(sat_add(64'(cur_sum[s]), 64'(cur), 64'(pse_pkg::MAX48)));
         nrg_sum[s] = 63'(sat_add(64'(nrg_sum[s]), de, 64'(pse_pkg::MAX63)));
         if (n_samp[s] != pse_pkg::MAX32) n_samp[s]++;
         if (cur > pk_cur[s]) pk_cur[s] = cur;
         r = mk_rec(pse_pkg::KIND_SAMPLE, s, cycles_done, 1'b1);
         r.current = cur;
         expected_recs.push_back(r);
      end else if (it.marker_byte == pse_pkg::SYNC_BYTE) begin
         if (!synced) begin
            synced = 1'b1;
            expected_recs.push_back(mk_rec(pse_pkg::KIND_SYNC, 3'd0, cycles_done, 1'b1));
         end
      end else if (it.marker_byte == pse_pkg::MARK_END) begin
         total = '0;
         if (in_cycle && open_ph >= 1 && open_ph <= NPH) t_end[open_ph] = it.time_us;
         cycles_done++;
         n_cycle_ends++;
         for (int p = 1; p <= NPH; p++) begin
            r = mk_rec(pse_pkg::KIND_PHASE, 3'(p), cycles_done, 1'b0);
            if (n_samp[p] != 0) begin
               total = 63'(sat_add(64'(total), 64'(nrg_sum[p]), 64'(pse_pkg::MAX63)));
               r.average = slot_avg(p);
               r.peak = pk_cur[p];
               r.duration_us = t_end[p] - t_start[p];
               r.energy = nrg_sum[p];
               r.has_samples = 1'b1;
            end
            expected_recs.push_back(r);
         end
         r = mk_rec(pse_pkg::KIND_IDLE, 3'd0, cycles_done, 1'b1);
         r.average = slot_avg(0);
         r.peak = pk_cur[0];
         r.energy = total;
         r.has_samples = (n_samp[0] != 0);
         expected_recs.push_back(r);
         clear_profile();
         open_ph = '0;
         in_cycle = 1'b0;
      end else if (it.marker_byte > pse_pkg::MARK_BASE
                   && it.marker_byte <= pse_pkg::MARK_BASE + NPH) begin
         np = 4'(it.marker_byte & pse_pkg::MARK_LOWNIB);
         if (in_cycle && open_ph >= 1 && open_ph < np) t_end[open_ph] = it.time_us;
         open_ph = np[2:0];
         t_start[open_ph] = it.time_us;
         if (np == 1) begin
            in_cycle = 1'b1;
            expected_recs.push_back(mk_rec(pse_pkg::KIND_START, 3'd1, cycles_done + 1,
                                           1'b1));
         end
      end
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // drive request transfers from the pending queue
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            profile_item(req_data);
            n_sent++;
            send_gap = gap_len();
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 &&
                         !(drain_pause && expected_recs.size() > 0)) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall and result checking
   int recv_gap = 0;
   always @(posedge clock) begin
      pse_pkg::rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            n_recs++;
            if (expected_recs.size() == 0) begin
               $error("unexpected record kind=%0d", rsp_data.kind);
               n_failures++;
            end else begin
               e = expected_recs.pop_front();
               if (e.kind != rsp_data.kind) begin
                  $error("kind exp %0d got %0d", e.kind, rsp_data.kind); n_failures++; end
               if (e.phase != rsp_data.phase) begin
                  $error("phase exp %0d got %0d", e.phase, rsp_data.phase); n_failures++; end
               if (e.cycle != rsp_data.cycle) begin
                  $error("cycle exp %0d got %0d", e.cycle, rsp_data.cycle); n_failures++; end
               if (e.current != rsp_data.current) begin
                  $error("current exp %0d got %0d", e.current, rsp_data.current);
                  n_failures++;
               end
               if (e.average != rsp_data.average) begin
                  $error("average exp %0d got %0d", e.average, rsp_data.average);
                  n_failures++;
               end
               if (e.peak != rsp_data.peak) begin
                  $error("peak exp %0d got %0d", e.peak, rsp_data.peak); n_failures++; end
               if (e.duration_us != rsp_data.duration_us) begin
                  $error("duration_us exp %0d got %0d", e.duration_us,
                         rsp_data.duration_us);
                  n_failures++;
               end
               if (e.energy != rsp_data.energy) begin
                  $error("energy exp %0d got %0d", e.energy, rsp_data.energy);
                  n_failures++;
               end
               if (e.has_samples != rsp_data.has_samples) begin
                  $error("has_samples exp %0d got %0d", e.has_samples,
                         rsp_data.has_samples);
                  n_failures++;
               end
               if (e.last != rsp_data.last) begin
                  $error("last exp %0d got %0d", e.last, rsp_data.last); n_failures++; end
            end
         end
         // hold off for a counted stretch when asked, else random gaps
         if (long_stall > 0) begin
            long_stall--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_gap = gap_len();
         end
      end
   end

   logic [31:0] stamp = 32'd0;

   function automatic pse_pkg::req_type sample_item(logic [15:0] cr, logic [14:0] v,
                                                    logic [31:0] t);
      pse_pkg::req_type q;
      q = '0;
      q.current_raw = cr;
      q.bus_voltage_mv = v;
      q.time_us = t;
      q.marker_byte = 8'($urandom);
      return q;
   endfunction

   function automatic pse_pkg::req_type marker_item(logic [7:0] m, logic [31:0] t);
      pse_pkg::req_type q;
      q = '0;
      q.func = 1'b1;
      q.marker_byte = m;
      q.time_us = t;
      q.current_raw = 16'($urandom);
      q.bus_voltage_mv = 15'($urandom);
      return q;
   endfunction

   task automatic add_sample();
      logic [15:0] cr;
      int r;
      r = $urandom_range(0, 9);
      cr = (r == 0) ? 16'($urandom) | 16'h8000
         : (r == 1) ? 16'h7FFF : 16'($urandom_range(0, 32767));
      stamp = stamp + ((r == 2) ? 32'($urandom) : 32'($urandom_range(0, 2000)));
      pending_reqs.push_back(sample_item(cr, 15'($urandom), stamp));
   endtask

   task automatic add_marker(logic [7:0] m);
      stamp = stamp + 32'($urandom_range(0, 500));
      pending_reqs.push_back(marker_item(m, stamp));
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_recs.size() > 0)
         @(posedge clock);
   endtask

   // stimulus
   initial begin
      int kind_sel;
      clear_profile();
      open_ph = '0; in_cycle = 1'b0; synced = 1'b0;
      cycles_done = '0; prev_stamp = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, sync handling, phase walks, empty phases
      pending_reqs.push_back(sample_item(16'h7FFF, 15'h7FFF, 32'hFFFF_FFFF));
      pending_reqs.push_back(sample_item(16'h8000, 15'h7FFF, 32'h0000_0010));
      pending_reqs.push_back(sample_item(16'hFFFF, 15'd0, 32'h0000_0020));
      pending_reqs.push_back(marker_item(pse_pkg::SYNC_BYTE, 32'd30));
      pending_reqs.push_back(marker_item(pse_pkg::SYNC_BYTE, 32'd31));
      pending_reqs.push_back(marker_item(8'h00, 32'd32));
      pending_reqs.push_back(marker_item(pse_pkg::MARK_BASE + 8'd3, 32'd40));
      pending_reqs.push_back(sample_item(16'd100, 15'd3300, 32'd50));
      pending_reqs.push_back(marker_item(pse_pkg::MARK_BASE + 8'd1, 32'd60));
      pending_reqs.push_back(sample_item(16'd500, 15'd5000, 32'd70));
      pending_reqs.push_back(marker_item(pse_pkg::MARK_BASE + 8'd4, 32'd80));
      pending_reqs.push_back(sample_item(16'h7FFF, 15'h7FFF, 32'hFFFF_FF00));
      pending_reqs.push_back(marker_item(pse_pkg::MARK_BASE + 8'd2, 32'd90));
      pending_reqs.push_back(sample_item(16'd7, 15'd1, 32'd100));
      pending_reqs.push_back(marker_item(pse_pkg::MARK_BASE + 8'd7, 32'd110));
      pending_reqs.push_back(marker_item(8'hA8, 32'd111));
      pending_reqs.push_back(marker_item(pse_pkg::MARK_END, 32'd120));
      pending_reqs.push_back(marker_item(pse_pkg::MARK_END, 32'd130));
      stamp = 32'd130;
      wait_drained();

      // fill the block while the receiver holds off
      long_stall = 300;
      for (int k = 0; k < 3; k++) add_sample();
      add_marker(pse_pkg::MARK_BASE + 8'd1);
      add_sample();
      add_marker(pse_pkg::MARK_END);
      wait_drained();

      // random cycles: mostly well-formed phase walks, some noise
      drain_pause = 1'b0;
      while (n_sent < 295) begin
         kind_sel = $urandom_range(0, 9);
         if (kind_sel < 7) begin
            add_marker(pse_pkg::MARK_BASE + 8'd1);
            for (int p = 1; p <= NPH; p++) begin
               if (p > 1 && $urandom_range(0, 4) != 0)
                  add_marker(pse_pkg::MARK_BASE + 8'(p));
               repeat ($urandom_range(0, 4)) add_sample();
            end
            if ($urandom_range(0, 3) == 0)
               add_marker(pse_pkg::MARK_BASE + 8'($urandom_range(1, NPH)));
            add_marker(pse_pkg::MARK_END);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 1)) add_sample();
               else add_marker(8'($urandom));
            end
         end
         if ($urandom_range(0, 5) == 0) drain_pause = 1'b1;
         while (pending_reqs.size() > 0) @(posedge clock);
         drain_pause = 1'b0;
      end
      wait_drained();
      repeat (500) @(posedge clock);
      if (expected_recs.size() > 0) begin
         $error("%0d records never arrived", expected_recs.size());
         n_failures++;
      end
      $display("Sent %0d items, checked %0d records across %0d cycle ends.",
               n_sent, n_recs, n_cycle_ends);
      if (n_failures == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #8000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ phase_segmented_energy_profiler.f @@
design/pse_pkg.sv
design/pse_div.sv
design/pse_datapath.sv
design/pse_ctrl.sv
design/phase_segmented_energy_profiler.sv
bench/tb_phase_segmented_energy_profiler.sv
